// File: rtl/core/sspr_pkg.sv
// ----------------------------------------------------------------------------
// sspr_pkg: shared types and constants for sprite screen projection
// Payload structs, angle constants, pipeline sizes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package sspr_pkg;

    // input beat
    typedef struct packed {
        logic signed [15:0] sprite_x;
        logic signed [15:0] sprite_y;
        logic signed [15:0] viewer_x;
        logic signed [15:0] viewer_y;
        logic signed [15:0] viewer_heading;
    } t_in;

    // output beat
    typedef struct packed {
        logic        [16:0] distance;
        logic signed [15:0] center_column;
        logic        [10:0] half_width;
        logic               visible;
    } t_out;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FOV  = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    localparam int ANG_PI       = 25736;
    localparam int ANG_HALF_PI  = 12868;
    localparam int MIN_DIST     = 26;
    localparam int FOV_RESET    = 6434;
    localparam int COLS_RESET   = 120;
    localparam int HW_MAX       = 2047;

    localparam int CORDIC_STEPS = 14;
    localparam int CW           = 28;   // CORDIC x/y width
    localparam int SQ_W         = 33;   // squared distance width
    localparam int SQRT_STEPS   = 17;
    localparam int COL_DW       = 28;   // column dividend magnitude width
    localparam int COL_VW       = 16;   // column divisor width (2*fov)
    localparam int DIST_W       = 17;
    localparam int LAT          = 48;   // beats in flight, input reg to output reg

    // atan(2^-i) in Q3.13
    function automatic logic signed [15:0] atan_q13(input int i);
        logic signed [15:0] v;
        case (i)
            0:       v = 16'sd6434;
            1:       v = 16'sd3798;
            2:       v = 16'sd2007;
            3:       v = 16'sd1019;
            4:       v = 16'sd511;
            5:       v = 16'sd256;
            6:       v = 16'sd128;
            7:       v = 16'sd64;
            8:       v = 16'sd32;
            9:       v = 16'sd16;
            10:      v = 16'sd8;
            11:      v = 16'sd4;
            12:      v = 16'sd2;
            13:      v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/sspr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sspr_sqrt_cell: one digit of the integer square root
// Tries one result bit against the running remainder and hands on.
// ----------------------------------------------------------------------------
module sspr_sqrt_cell import sspr_pkg::*; #(
    parameter int K = 0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SQ_W-1:0] i_n,
    input  logic [SQ_W-1:0] i_res,
    output logic [SQ_W-1:0] o_n,
    output logic [SQ_W-1:0] o_res
);

    logic [SQ_W-1:0] w_bit;
    logic [SQ_W:0]   w_sum;
    logic            w_ge;
    logic [SQ_W-1:0] n_n, n_res;
    logic [SQ_W-1:0] r_n, r_res;

    // trial subtract of res + bit
    always_comb begin
        w_bit = SQ_W'(1) << K;
        w_sum = {1'b0, i_res} + {1'b0, w_bit};
        w_ge  = {1'b0, i_n} >= w_sum;
        n_n   = w_ge ? (i_n - w_sum[SQ_W-1:0]) : i_n;
        n_res = w_ge ? ((i_res >> 1) + w_bit) : (i_res >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= n_n;
            r_res <= n_res;
        end
    end

    assign o_n   = r_n;
    assign o_res = r_res;

endmodule

// File: rtl/core/sspr_cordic_cell.sv
// ----------------------------------------------------------------------------
// sspr_cordic_cell: one vectoring micro-rotation
// Rotates (x, y) toward the x axis and accumulates the angle.
// ----------------------------------------------------------------------------
module sspr_cordic_cell import sspr_pkg::*; #(
    parameter int I = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [15:0]   i_z,
    input  logic                 i_zero,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [15:0]   o_z,
    output logic                 o_zero
);

    logic signed [CW-1:0] w_xs, w_ys;
    logic signed [CW-1:0] n_x, n_y;
    logic signed [15:0]   n_z;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [15:0]   r_z;
    logic                 r_zero;

    // rotate toward positive angle while residual y is above zero
    always_comb begin
        w_xs = i_x >>> I;
        w_ys = i_y >>> I;
        if (i_y > 0) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + atan_q13(I);
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - atan_q13(I);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_zero <= i_zero;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_zero = r_zero;

endmodule

// File: rtl/core/sspr_div_cell.sv
// ----------------------------------------------------------------------------
// sspr_div_cell: one restoring division step
// Shifts in one dividend bit, subtracts the divisor if it fits, emits a
// quotient bit into the low end of the shared dividend/quotient word.
// ----------------------------------------------------------------------------
module sspr_div_cell #(
    parameter int DW = 28,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [VW-1:0] i_rem,
    input  logic [DW-1:0] i_qr,
    input  logic [VW-1:0] i_div,
    output logic [VW-1:0] o_rem,
    output logic [DW-1:0] o_qr,
    output logic [VW-1:0] o_div
);

    logic [VW:0]   w_trial;
    logic          w_ge;
    logic [VW:0]   w_diff;
    logic [VW-1:0] n_rem;
    logic [DW-1:0] n_qr;
    logic [VW-1:0] r_rem, r_div;
    logic [DW-1:0] r_qr;

    always_comb begin
        w_trial = {i_rem, i_qr[DW-1]};
        w_ge    = w_trial >= {1'b0, i_div};
        w_diff  = w_trial - {1'b0, i_div};
        n_rem   = w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
        n_qr    = {i_qr[DW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_qr  <= n_qr;
            r_div <= i_div;
        end
    end

    assign o_rem = r_rem;
    assign o_qr  = r_qr;
    assign o_div = r_div;

endmodule

// File: rtl/core/sprite_screen_projection_core.sv
// ----------------------------------------------------------------------------
// sprite_screen_projection_core: billboard sprite projection pipeline
// Distance, bearing, screen column, half width and visibility per sprite.
// ----------------------------------------------------------------------------
// One sprite beat is accepted every cycle unless the pipeline holds; the
// whole pipeline advances together and holds only while a finished
// result waits at the output. The latency is set by the longest chain
// of cells: two setup stages, the 14-cell CORDIC, the angle wrap stage,
// two stages to form the column dividend and the 28-cell column divider,
// then the output register. The 17-cell square root and the half-width
// divider run alongside and are padded to line up.
// Configuration writes are taken in any cycle and must land only while the
// pipeline is empty.
module sprite_screen_projection_core import sspr_pkg::*; #(
    parameter int SPRITE_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int HW_DEND = SPRITE_SIZE * 2048;
    localparam int HW_N    = $clog2(HW_DEND + 1);
    localparam int HW_PAD  = COL_DW - HW_N;

    logic w_en;

    // configuration registers
    logic [14:0] r_fov;
    logic [10:0] r_cols;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fov  <= 15'(FOV_RESET);
            r_cols <= 11'(COLS_RESET);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FOV:  r_fov  <= i_cfg_data[14:0];
                CFG_COLS: r_cols <= i_cfg_data[10:0];
                default:  ;
            endcase
        end
    end

    // pipeline valid chain; everything moves when the output slot frees up
    logic [LAT-1:0] r_vld;

    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // stage 1: deltas
    logic signed [16:0] r_dx, r_dy;
    logic signed [15:0] r_hd [16];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx    <= 17'(i_in_data.sprite_x) - 17'(i_in_data.viewer_x);
            r_dy    <= 17'(i_in_data.sprite_y) - 17'(i_in_data.viewer_y);
            r_hd[0] <= i_in_data.viewer_heading;
            for (int k = 1; k < 16; k++) begin
                r_hd[k] <= r_hd[k-1];
            end
        end
    end

    // stage 2: squares and CORDIC quarter-turn pre-rotation
    logic signed [33:0]   w_sx2, w_sy2, w_sq;
    logic signed [CW-1:0] w_x0, w_y0, n_cx, n_cy;
    logic signed [15:0]   n_cz;
    logic [SQ_W-1:0]      r_sq;
    logic signed [CW-1:0] c_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] c_y [CORDIC_STEPS+1];
    logic signed [15:0]   c_z [CORDIC_STEPS+1];
    logic                 c_zero [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_cx0, r_cy0;
    logic signed [15:0]   r_cz0;
    logic                 r_czero0;

    assign w_sx2 = r_dx * r_dx;
    assign w_sy2 = r_dy * r_dy;
    assign w_sq  = w_sx2 + w_sy2;

    always_comb begin
        w_x0 = CW'(r_dy) <<< 8;
        w_y0 = CW'(r_dx) <<< 8;
        n_cx = w_x0;
        n_cy = w_y0;
        n_cz = '0;
        if (w_x0 < 0) begin
            if (w_y0 >= 0) begin
                n_cx = w_y0;
                n_cy = -w_x0;
                n_cz = 16'(ANG_HALF_PI);
            end else begin
                n_cx = -w_y0;
                n_cy = w_x0;
                n_cz = -16'(ANG_HALF_PI);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq     <= w_sq[SQ_W-1:0];
            r_cx0    <= n_cx;
            r_cy0    <= n_cy;
            r_cz0    <= n_cz;
            r_czero0 <= (r_dx == '0) && (r_dy == '0);
        end
    end

    assign c_x[0]    = r_cx0;
    assign c_y[0]    = r_cy0;
    assign c_z[0]    = r_cz0;
    assign c_zero[0] = r_czero0;

    // CORDIC chain, stages 3 to 16
    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
        sspr_cordic_cell #(.I(gi)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_x    (c_x[gi]),
            .i_y    (c_y[gi]),
            .i_z    (c_z[gi]),
            .i_zero (c_zero[gi]),
            .o_x    (c_x[gi+1]),
            .o_y    (c_y[gi+1]),
            .o_z    (c_z[gi+1]),
            .o_zero (c_zero[gi+1])
        );
    end

    // square root chain, stages 3 to 19
    logic [SQ_W-1:0] s_n   [SQRT_STEPS+1];
    logic [SQ_W-1:0] s_res [SQRT_STEPS+1];

    assign s_n[0]   = r_sq;
    assign s_res[0] = '0;

    for (genvar gk = 0; gk < SQRT_STEPS; gk++) begin : g_sqrt
        sspr_sqrt_cell #(.K(2 * (SQRT_STEPS - 1 - gk))) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_n   (s_n[gk]),
            .i_res (s_res[gk]),
            .o_n   (s_n[gk+1]),
            .o_res (s_res[gk+1])
        );
    end

    // stage 17: angle difference, wrapped into minus pi to pi
    logic signed [17:0] w_diff, n_diff;
    logic signed [16:0] r_diff;

    always_comb begin
        w_diff = (c_zero[CORDIC_STEPS] ? 18'sd0 : 18'(c_z[CORDIC_STEPS]))
               - 18'(r_hd[15]);
        n_diff = w_diff;
        if (w_diff < -18'(ANG_PI)) begin
            n_diff = w_diff + 18'(2 * ANG_PI);
        end else if (w_diff > 18'(ANG_PI)) begin
            n_diff = w_diff - 18'(2 * ANG_PI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_diff <= 17'(n_diff);
        end
    end

    // stage 18: column dividend (2*diff + fov) * cols
    logic [14:0]        w_fov1;
    logic signed [17:0] w_num;
    logic signed [29:0] w_prod;
    logic signed [29:0] r_prod;

    assign w_fov1 = (r_fov == '0) ? 15'd1 : r_fov;
    assign w_num  = (18'(r_diff) <<< 1) + 18'($signed({1'b0, w_fov1}));
    assign w_prod = w_num * $signed({1'b0, r_cols});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= w_prod;
        end
    end

    // stage 19: sign and magnitude
    logic signed [29:0] w_mag;
    logic [COL_DW-1:0]  r_cmag;
    logic               r_csign;

    assign w_mag = r_prod[29] ? -r_prod : r_prod;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmag  <= w_mag[COL_DW-1:0];
            r_csign <= r_prod[29];
        end
    end

    // column divider, stages 20 to 47
    logic [COL_VW-1:0] d_rem [COL_DW+1];
    logic [COL_DW-1:0] d_qr  [COL_DW+1];
    logic [COL_VW-1:0] d_div [COL_DW+1];
    logic              r_csg [COL_DW];

    assign d_rem[0] = '0;
    assign d_qr[0]  = r_cmag;
    assign d_div[0] = {w_fov1, 1'b0};

    for (genvar gd = 0; gd < COL_DW; gd++) begin : g_cdiv
        sspr_div_cell #(.DW(COL_DW), .VW(COL_VW)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (d_rem[gd]),
            .i_qr  (d_qr[gd]),
            .i_div (d_div[gd]),
            .o_rem (d_rem[gd+1]),
            .o_qr  (d_qr[gd+1]),
            .o_div (d_div[gd+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_csg[0] <= r_csign;
            for (int k = 1; k < COL_DW; k++) begin
                r_csg[k] <= r_csg[k-1];
            end
        end
    end

    // half-width divider, from stage 20, divisor is the clamped distance
    logic [DIST_W-1:0] w_dist;
    logic [DIST_W-1:0] h_rem [HW_N+1];
    logic [HW_N-1:0]   h_qr  [HW_N+1];
    logic [DIST_W-1:0] h_div [HW_N+1];

    assign w_dist   = s_res[SQRT_STEPS][DIST_W-1:0];
    assign h_rem[0] = '0;
    assign h_qr[0]  = HW_N'(HW_DEND);
    assign h_div[0] = (w_dist < DIST_W'(MIN_DIST)) ? DIST_W'(MIN_DIST) : w_dist;

    for (genvar gh = 0; gh < HW_N; gh++) begin : g_hdiv
        sspr_div_cell #(.DW(HW_N), .VW(DIST_W)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (h_rem[gh]),
            .i_qr  (h_qr[gh]),
            .i_div (h_div[gh]),
            .o_rem (h_rem[gh+1]),
            .o_qr  (h_qr[gh+1]),
            .o_div (h_div[gh+1])
        );
    end

    // line up the half-width quotient and distance with the column divider
    logic [HW_N-1:0]   r_pq [HW_PAD];
    logic [DIST_W-1:0] r_pd [HW_PAD];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pq[0] <= h_qr[HW_N];
            r_pd[0] <= h_div[HW_N];
            for (int k = 1; k < HW_PAD; k++) begin
                r_pq[k] <= r_pq[k-1];
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    // stage 48: saturate, visibility, output register
    logic signed [COL_DW:0] w_col_full;
    logic signed [15:0]     w_col;
    logic [HW_N-1:0]        w_hq;
    logic [10:0]            w_hw;
    logic signed [17:0]     w_left, w_right;
    t_out                   r_out;

    always_comb begin
        w_col_full = r_csg[COL_DW-1] ? -$signed({1'b0, d_qr[COL_DW]})
                                     :  $signed({1'b0, d_qr[COL_DW]});
        if (w_col_full > (COL_DW+1)'(32767)) begin
            w_col = 16'sd32767;
        end else if (w_col_full < -(COL_DW+1)'(32768)) begin
            w_col = -16'sd32768;
        end else begin
            w_col = 16'(w_col_full);
        end
        w_hq = r_pq[HW_PAD-1] >> 1;
        w_hw = (w_hq > HW_N'(HW_MAX)) ? 11'(HW_MAX) : 11'(w_hq);
        w_left  = 18'(w_col) + 18'($signed({1'b0, w_hw}));
        w_right = 18'(w_col) - 18'($signed({1'b0, w_hw}));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.distance      <= r_pd[HW_PAD-1];
            r_out.center_column <= w_col;
            r_out.half_width    <= w_hw;
            r_out.visible       <= !((w_left < 0) ||
                                     (w_right >= 18'($signed({1'b0, r_cols}))));
        end
    end

    assign o_out_data = r_out;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for sprite_screen_projection_core
// Drives sprite beats and register writes, predicts distance, screen column,
// half width and visibility per sprite, and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import sspr_pkg::*;

    localparam int SPRITE_SZ  = 32;
    localparam int CYCLE_CAP  = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    sprite_screen_projection_core #(.SPRITE_SIZE(SPRITE_SZ)) dut (.*);

    // predictor copy of the registers
    logic [14:0] fov_q13;
    logic [10:0] col_count;

    t_out  proj_expected[$];
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_off_cycles;
    int    fail_count;
    int    beats_sent;
    int    beats_checked;
    int    cfg_writes;
    longint cycle_count;

    // clock
    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout at %0t", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    // floor shift of a signed value
    function automatic longint fshift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint sqrt_floor(input longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // CORDIC bearing measured from the y axis, Q3.13
    function automatic longint bearing_q13(input longint dx, input longint dy);
        longint x, y, z, t, xs, ys;
        longint atab[14];
        atab = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        x = dy * 256;
        y = dx * 256;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = ANG_HALF_PI;
            end else begin
                x = -y; y = t; z = -ANG_HALF_PI;
            end
        end
        for (int i = 0; i < 14; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += atab[i];
            end else begin
                x -= ys; y += xs; z -= atab[i];
            end
        end
        return z;
    endfunction

    function automatic t_out project_sprite(input t_in s);
        t_out   r;
        longint dx, dy, dist_q8, diff, fov, cols, col, hw;
        dx = longint'(s.sprite_x) - longint'(s.viewer_x);
        dy = longint'(s.sprite_y) - longint'(s.viewer_y);
        dist_q8 = sqrt_floor(dx * dx + dy * dy);
        if (dist_q8 < MIN_DIST) dist_q8 = MIN_DIST;
        diff = bearing_q13(dx, dy) - longint'(s.viewer_heading);
        while (diff < -ANG_PI) diff += 2 * ANG_PI;
        while (diff > ANG_PI) diff -= 2 * ANG_PI;
        fov = fov_q13;
        if (fov == 0) fov = 1;
        cols = col_count;
        col = ((2 * diff + fov) * cols) / (2 * fov);
        if (col > 32767) col = 32767;
        if (col < -32768) col = -32768;
        hw = ((SPRITE_SZ * 8 * 256) / dist_q8) / 2;
        if (hw > HW_MAX) hw = HW_MAX;
        r.distance      = dist_q8[16:0];
        r.center_column = col[15:0];
        r.half_width    = hw[10:0];
        r.visible       = !(col + hw < 0 || col - hw >= cols);
        return r;
    endfunction

    // send one sprite beat; valid stays high across back-to-back beats
    task automatic send_sprite(input t_in s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        proj_expected.push_back(project_sprite(s));
        beats_sent++;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (proj_expected.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FOV) fov_q13 = val[14:0];
        else col_count = val[10:0];
        cfg_writes++;
    endtask

    function automatic t_in random_sprite(input bit near);
        t_in s;
        s = t_in'(80'({$urandom, $urandom, $urandom}));
        if (near) begin
            // viewer close to sprite so distance and width stay moderate
            s.viewer_x = s.sprite_x + 16'($signed($urandom_range(0, 4096)) - 2048);
            s.viewer_y = s.sprite_y + 16'($signed($urandom_range(0, 4096)) - 2048);
            s.viewer_heading = 16'($signed($urandom_range(0, 51472)) - 25736);
        end
        return s;
    endfunction

    // result beats: random stall, compare with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (proj_expected.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_data);
                    fail_count++;
                end else begin
                    t_out e;
                    e = proj_expected.pop_front();
                    beats_checked++;
                    if (e !== o_out_data) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, o_out_data);
                        fail_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic test_directed();
        t_in s;
        logic signed [15:0] ext[4];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1};
        foreach (ext[i]) begin
            s = '{ext[i], ext[3 - i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[i]};
            send_sprite(s);
        end
        // coincident positions
        send_sprite('{16'sd100, -16'sd50, 16'sd100, -16'sd50, 16'sd0});
        // straight ahead, behind, left, right at short range
        send_sprite('{16'sd0, 16'sd512, 16'sd0, 16'sd0, 16'sd0});
        send_sprite('{16'sd0, -16'sd512, 16'sd0, 16'sd0, 16'sd0});
        send_sprite('{-16'sd512, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_sprite('{16'sd512, -16'sd3, 16'sd0, 16'sd0, 16'sd0});
        // headings outside minus pi to pi
        send_sprite('{16'sd300, 16'sd200, 16'sd0, 16'sd0, 16'sh7fff});
        send_sprite('{16'sd300, -16'sd200, 16'sd0, 16'sd0, 16'sh8000});
        // very close sprites: distance at or near the minimum clamp, wide half width
        send_sprite('{16'sd1, 16'sd2, 16'sd0, 16'sd0, 16'sd0});
        send_sprite('{16'sd20, 16'sd20, 16'sd0, 16'sd0, 16'sd100});
        drain_pipeline();
    endtask

    task automatic test_config_extremes();
        logic [15:0] fovs[5];
        logic [15:0] cols[5];
        fovs = '{16'd0, 16'd819, 16'd25736, 16'h7fff, 16'd6434};
        cols = '{16'd0, 16'd1, 16'd1024, 16'h07ff, 16'd120};
        foreach (fovs[i]) begin
            write_reg(CFG_FOV, fovs[i]);
            write_reg(CFG_COLS, cols[i]);
            for (int k = 0; k < 20; k++) send_sprite(random_sprite(k % 2 == 0));
            drain_pipeline();
        end
    endtask

    task automatic test_random(input int n_items, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        write_reg(CFG_FOV, 16'($urandom_range(819, 25736)));
        write_reg(CFG_COLS, 16'($urandom_range(1, 1024)));
        for (int k = 0; k < n_items; k++)
            send_sprite(random_sprite($urandom_range(99) < 75));
        drain_pipeline();
    endtask

    // receiver held off while the sender keeps offering beats
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 200;
        for (int k = 0; k < 120; k++) send_sprite(random_sprite(1'b1));
        drain_pipeline();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FOV;
        i_cfg_data = '0;
        fov_q13 = 15'(FOV_RESET);
        col_count = 11'(COLS_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        fail_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        cfg_writes = 0;
        cycle_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random(450, 0, 0);
        test_random(400, 69, 0);
        test_random(400, 0, 69);
        test_random(400, 28, 28);

        $display("Covered directed extremes, %0d register writes, long output hold-off,",
                 cfg_writes);
        $display("and %0d sprites sent, %0d results checked.", beats_sent, beats_checked);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
